FILE: rtl/tilt_to_four_way_stick_macros.svh
// Assertion macros used by the axis selection module of the tilt-to-stick RTL.
`ifndef TILT_TO_FOUR_WAY_STICK_MACROS_SVH
`define TILT_TO_FOUR_WAY_STICK_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define TTFS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TTFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ttfs_pkg.sv
// Package with the types and constants of the tilt-to-stick block.
package ttfs_pkg;

   // Which axis currently owns the stick.
   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_HORZ = 2'd1,
      AXIS_VERT = 2'd2
   } axis_type;

   // Quantized direction on one axis: hit is set beyond the threshold,
   // neg gives the side (left or down when set).
   typedef struct packed {
      logic hit;
      logic neg;
   } dir_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TWIST_THR = 3'd0;
   localparam logic [2:0] CSR_TIP_THR   = 3'd1;
   localparam logic [2:0] CSR_STICK     = 3'd2;
   localparam logic [2:0] CSR_FLIP_TWST = 3'd3;
   localparam logic [2:0] CSR_FLIP_TIP  = 3'd4;

   localparam int THR_W   = 15;
   localparam int STICK_W = 6;
   localparam int CSR_W   = 15;

   localparam logic [THR_W-1:0]   TWIST_THR_RESET = 15'd1280;
   localparam logic [THR_W-1:0]   TIP_THR_RESET   = 15'd1024;
   localparam logic [STICK_W-1:0] STICK_RESET     = 6'd24;

   // Active-low bit positions in the port bytes.
   localparam int BIT_UP    = 0;
   localparam int BIT_LEFT  = 1;
   localparam int BIT_RIGHT = 2;
   localparam int BIT_DOWN  = 3;
   localparam int BIT_COIN  = 5;
   localparam int BIT_START = 5;

   localparam logic [7:0] PORT_IDLE = 8'hFF;

endpackage

FILE: rtl/ttfs_req_if.sv
// Poll item channel: valid, ready and the sensor payload.
interface ttfs_req_if #(
   parameter int ANGLE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic                         recentre;
   logic                         tilt_new;
   logic signed [ANGLE_BITS-1:0] twist_angle;
   logic signed [ANGLE_BITS-1:0] tip_angle;
   logic                         coin_pressed;
   logic                         start_pressed;

   modport source (
      output valid, recentre, tilt_new, twist_angle, tip_angle, coin_pressed,
             start_pressed,
      input  ready
   );
   modport sink (
      input  valid, recentre, tilt_new, twist_angle, tip_angle, coin_pressed,
             start_pressed,
      output ready
   );
endinterface

FILE: rtl/ttfs_rsp_if.sv
// Port byte channel: valid, ready and the two active-low port bytes.
interface ttfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] port_zero;
   logic [7:0] port_one;

   modport source (
      output valid, port_zero, port_one,
      input  ready
   );
   modport sink (
      input  valid, port_zero, port_one,
      output ready
   );
endinterface

FILE: rtl/tilt_to_four_way_stick.sv
// Top level of the tilt-to-stick block: channels, registers and pipeline.
//
// This block turns tilt sensor polls into the active-low joystick port bytes
// of an arcade board. It takes one poll item in every clock cycle while the
// result side does not stall, and passes each through the input register and
// then the result register as one item of two port bytes. The rate is set by
// the single pass of negation, threshold compare and takeover multiply that
// sits between those two registers. The request side drops ready only while
// both registers hold items and the result side is not taking one, so a
// stalled consumer causes back pressure but no loss. Each angle is optionally
// negated (the most negative code saturates), then compared strictly against
// its own threshold. When both axes clear their thresholds the axis already
// held keeps control unless the other one's magnitude exceeds it by the stick
// factor in sixteenths; with no axis held the larger magnitude wins and the
// vertical axis takes a tie. A recentre item clears the held axis and both
// directions before its own tilt is applied; an item with stale tilt and no
// recentre leaves the directions as they were. Configuration registers must
// be written through the csr port only while no item is in flight, which the
// block does not enforce; indexes beyond the last register are ignored.
module tilt_to_four_way_stick #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   ttfs_req_if.sink                      req_chan,
   ttfs_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [ttfs_pkg::CSR_W-1:0]    csr_wdata
);
   // Configuration registers.
   logic [ttfs_pkg::THR_W-1:0]   twist_thr_ff;
   logic [ttfs_pkg::THR_W-1:0]   tip_thr_ff;
   logic [ttfs_pkg::STICK_W-1:0] stick_ff;
   logic                         flip_twist_ff;
   logic                         flip_tip_ff;

   // Input register.
   logic                         in_valid_ff;
   logic                         recentre_ff;
   logic                         fresh_ff;
   logic signed [ANGLE_BITS-1:0] twist_ff;
   logic signed [ANGLE_BITS-1:0] tip_ff;
   logic                         coin_ff;
   logic                         start_ff;

   // Result register.
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [7:0]                   port_zero_ff;
   logic [7:0]                   port_one_ff;
   logic [7:0]                   port_zero_in;
   logic [7:0]                   port_one_in;

   logic                         out_free;
   logic                         advance;
   logic                         req_take;

   ttfs_pkg::dir_type            horz_quant;
   ttfs_pkg::dir_type            vert_quant;
   ttfs_pkg::dir_type            horz_next;
   ttfs_pkg::dir_type            vert_next;
   logic [ANGLE_BITS-1:0]        horz_mag;
   logic [ANGLE_BITS-1:0]        vert_mag;

   // The result register can load when it is empty or being emptied now.
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign advance   = in_valid_ff && out_free;
   assign req_take  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         twist_thr_ff  <= ttfs_pkg::TWIST_THR_RESET;
         tip_thr_ff    <= ttfs_pkg::TIP_THR_RESET;
         stick_ff      <= ttfs_pkg::STICK_RESET;
         flip_twist_ff <= 1'b1;
         flip_tip_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            ttfs_pkg::CSR_TWIST_THR: begin
               twist_thr_ff <= csr_wdata[ttfs_pkg::THR_W-1:0];
            end
            ttfs_pkg::CSR_TIP_THR: begin
               tip_thr_ff <= csr_wdata[ttfs_pkg::THR_W-1:0];
            end
            ttfs_pkg::CSR_STICK: begin
               stick_ff <= csr_wdata[ttfs_pkg::STICK_W-1:0];
            end
            ttfs_pkg::CSR_FLIP_TWST: begin
               flip_twist_ff <= csr_wdata[0];
            end
            ttfs_pkg::CSR_FLIP_TIP: begin
               flip_tip_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register: valid is control, the payload loads on acceptance.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         recentre_ff <= req_chan.recentre;
         fresh_ff    <= req_chan.tilt_new;
         twist_ff    <= req_chan.twist_angle;
         tip_ff      <= req_chan.tip_angle;
         coin_ff     <= req_chan.coin_pressed;
         start_ff    <= req_chan.start_pressed;
      end
   end

   // Twist drives left and right, tip drives up and down.
   ttfs_axis #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_twist (
      .angle     (twist_ff),
      .threshold (twist_thr_ff),
      .flip      (flip_twist_ff),
      .dir       (horz_quant),
      .magnitude (horz_mag)
   );

   ttfs_axis #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_tip (
      .angle     (tip_ff),
      .threshold (tip_thr_ff),
      .flip      (flip_tip_ff),
      .dir       (vert_quant),
      .magnitude (vert_mag)
   );

   // The stick state moves on only when an item passes into the result register.
   ttfs_select #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_select (
      .clock        (clock),
      .reset        (reset),
      .update       (advance),
      .recentre     (recentre_ff),
      .tilt_new     (fresh_ff),
      .horz_quant   (horz_quant),
      .vert_quant   (vert_quant),
      .horz_mag     (horz_mag),
      .vert_mag     (vert_mag),
      .stick_factor (stick_ff),
      .horz_next    (horz_next),
      .vert_next    (vert_next)
   );

   // Port bytes are active low; unused bits stay high.
   always_comb begin
      port_zero_in = ttfs_pkg::PORT_IDLE;
      port_one_in  = ttfs_pkg::PORT_IDLE;
      port_zero_in[ttfs_pkg::BIT_UP]    = !(vert_next.hit && !vert_next.neg);
      port_zero_in[ttfs_pkg::BIT_LEFT]  = !(horz_next.hit && horz_next.neg);
      port_zero_in[ttfs_pkg::BIT_RIGHT] = !(horz_next.hit && !horz_next.neg);
      port_zero_in[ttfs_pkg::BIT_DOWN]  = !(vert_next.hit && vert_next.neg);
      port_zero_in[ttfs_pkg::BIT_COIN]  = !coin_ff;
      port_one_in[ttfs_pkg::BIT_START]  = !start_ff;
   end

   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         port_zero_ff <= port_zero_in;
         port_one_ff  <= port_one_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.port_zero = port_zero_ff;
   assign rsp_chan.port_one  = port_one_ff;
endmodule

FILE: rtl/ttfs_axis.sv
// One tilt axis: optional saturating negation, magnitude and threshold test.
module ttfs_axis #(
   parameter int ANGLE_BITS = 16
) (
   input  logic signed [ANGLE_BITS-1:0]     angle,
   input  logic [ttfs_pkg::THR_W-1:0]       threshold,
   input  logic                             flip,
   output ttfs_pkg::dir_type                dir,
   output logic [ANGLE_BITS-1:0]            magnitude
);
   localparam int CMP_W = ((ANGLE_BITS > ttfs_pkg::THR_W) ? ANGLE_BITS : ttfs_pkg::THR_W) + 1;
   localparam logic signed [ANGLE_BITS-1:0] MOST_NEG = {1'b1, {(ANGLE_BITS-1){1'b0}}};
   localparam logic signed [ANGLE_BITS-1:0] MOST_POS = {1'b0, {(ANGLE_BITS-1){1'b1}}};

   logic signed [ANGLE_BITS-1:0] negated;
   logic signed [ANGLE_BITS-1:0] value;

   // Negating the most negative code saturates instead of wrapping.
   assign negated   = (angle == MOST_NEG) ? MOST_POS : -angle;
   assign value     = flip ? negated : angle;
   // The most negative code gives 2^(ANGLE_BITS-1), which still fits unsigned.
   assign magnitude = value[ANGLE_BITS-1] ? (~value + 1'b1) : value;

   assign dir.hit = CMP_W'(magnitude) > CMP_W'(threshold);
   assign dir.neg = value[ANGLE_BITS-1];
endmodule

FILE: rtl/ttfs_select.sv
// Axis arbitration and the held axis and direction registers.
`include "tilt_to_four_way_stick_macros.svh"

module ttfs_select #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic                          recentre,
   input  logic                          tilt_new,
   input  ttfs_pkg::dir_type             horz_quant,
   input  ttfs_pkg::dir_type             vert_quant,
   input  logic [ANGLE_BITS-1:0]         horz_mag,
   input  logic [ANGLE_BITS-1:0]         vert_mag,
   input  logic [ttfs_pkg::STICK_W-1:0]  stick_factor,
   output ttfs_pkg::dir_type             horz_next,
   output ttfs_pkg::dir_type             vert_next
);
   localparam int PROD_W = ANGLE_BITS + ttfs_pkg::STICK_W;

   ttfs_pkg::axis_type held_axis_ff, held_axis_in;
   ttfs_pkg::dir_type  horz_dir_ff, horz_dir_in;
   ttfs_pkg::dir_type  vert_dir_ff, vert_dir_in;

   ttfs_pkg::axis_type base_axis;
   ttfs_pkg::axis_type pick;
   logic [PROD_W-1:0]  horz_scaled;
   logic [PROD_W-1:0]  vert_scaled;
   logic [PROD_W-1:0]  horz_times_sf;
   logic [PROD_W-1:0]  vert_times_sf;
   logic               vert_takes;
   logic               horz_takes;

   logic [5:0]         stick_state;
   logic               dirs_exclusive;
   logic               dirs_held;
   logic               stick_idle;
   logic               clear_item;
   logic               stale_item;

   // Sixteenths: compare 16 times the challenger with factor times the holder.
   assign horz_scaled   = PROD_W'({horz_mag, 4'b0000});
   assign vert_scaled   = PROD_W'({vert_mag, 4'b0000});
   assign horz_times_sf = PROD_W'(horz_mag) * PROD_W'(stick_factor);
   assign vert_times_sf = PROD_W'(vert_mag) * PROD_W'(stick_factor);
   assign vert_takes    = vert_scaled > horz_times_sf;
   assign horz_takes    = horz_scaled > vert_times_sf;

   assign base_axis = recentre ? ttfs_pkg::AXIS_NONE : held_axis_ff;

   always_comb begin
      if (!horz_quant.hit && !vert_quant.hit) begin
         pick = ttfs_pkg::AXIS_NONE;
      end else if (!vert_quant.hit) begin
         pick = ttfs_pkg::AXIS_HORZ;
      end else if (!horz_quant.hit) begin
         pick = ttfs_pkg::AXIS_VERT;
      end else if (base_axis == ttfs_pkg::AXIS_HORZ) begin
         pick = vert_takes ? ttfs_pkg::AXIS_VERT : ttfs_pkg::AXIS_HORZ;
      end else if (base_axis == ttfs_pkg::AXIS_VERT) begin
         pick = horz_takes ? ttfs_pkg::AXIS_HORZ : ttfs_pkg::AXIS_VERT;
      end else begin
         pick = (horz_mag > vert_mag) ? ttfs_pkg::AXIS_HORZ : ttfs_pkg::AXIS_VERT;
      end
   end

   always_comb begin
      if (tilt_new) begin
         held_axis_in = pick;
         horz_dir_in  = (pick == ttfs_pkg::AXIS_HORZ) ? horz_quant : '0;
         vert_dir_in  = (pick == ttfs_pkg::AXIS_VERT) ? vert_quant : '0;
      end else if (recentre) begin
         held_axis_in = ttfs_pkg::AXIS_NONE;
         horz_dir_in  = '0;
         vert_dir_in  = '0;
      end else begin
         held_axis_in = held_axis_ff;
         horz_dir_in  = horz_dir_ff;
         vert_dir_in  = vert_dir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_axis_ff <= ttfs_pkg::AXIS_NONE;
         horz_dir_ff  <= '0;
         vert_dir_ff  <= '0;
      end else if (update) begin
         held_axis_ff <= held_axis_in;
         horz_dir_ff  <= horz_dir_in;
         vert_dir_ff  <= vert_dir_in;
      end
   end

   assign horz_next = horz_dir_in;
   assign vert_next = vert_dir_in;

   assign stick_state    = {held_axis_ff, horz_dir_ff, vert_dir_ff};
   assign dirs_exclusive = !(horz_dir_ff.hit && vert_dir_ff.hit);
   assign dirs_held      = (held_axis_ff == ttfs_pkg::AXIS_HORZ || !horz_dir_ff.hit) &&
                           (held_axis_ff == ttfs_pkg::AXIS_VERT || !vert_dir_ff.hit);
   assign stick_idle     = (held_axis_ff == ttfs_pkg::AXIS_NONE) &&
                           !horz_dir_ff.hit && !vert_dir_ff.hit;
   assign clear_item     = update && recentre && !tilt_new;
   assign stale_item     = update && !recentre && !tilt_new;

   `TTFS_ASSERT_SAME(a_one_direction, clock, reset, 1'b1, dirs_exclusive, "two directions")
   `TTFS_ASSERT_SAME(a_dir_axis, clock, reset, 1'b1, dirs_held, "direction on an unheld axis")
   `TTFS_ASSERT_NEXT(a_recentre, clock, reset, clear_item, stick_idle, "recentre missed")
   `TTFS_ASSERT_NEXT(a_stale, clock, reset, stale_item, $stable(stick_state), "stale tilt moved")
endmodule
